// ===== sv/ppq_pkg.sv =====
package ppq_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_ADD      = 2'd0;
   localparam mode_type MODE_DISPATCH = 2'd1;
   localparam mode_type MODE_REMOVE   = 2'd2;

   localparam op_type OP_ADD      = 2'd0;
   localparam op_type OP_DISPATCH = 2'd1;
   localparam op_type OP_REMOVE   = 2'd2;
   localparam op_type OP_NOP      = 2'd3;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_NOT_FOUND = 2'd2;

endpackage

// ===== sv/ppq_front.sv =====
module ppq_front #(
   parameter int ID_BITS   = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppq_pkg::mode_type     req_mode,
   input  logic [ID_BITS-1:0]    req_pid,
   input  logic [PRIO_BITS-1:0]  req_prio,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output ppq_pkg::op_type       cmd_op,
   output logic [ID_BITS-1:0]    cmd_pid,
   output logic [PRIO_BITS-1:0]  cmd_prio
);

   localparam int Slots = 2;

   ppq_pkg::op_type       op_ff   [Slots];
   logic [ID_BITS-1:0]    pid_ff  [Slots];
   logic [PRIO_BITS-1:0]  prio_ff [Slots];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;

   ppq_pkg::op_type       dec_op;
   logic [PRIO_BITS-1:0]  dec_prio;
   logic                  push, pop;

   // classify the incoming beat
   always_comb begin
      unique case (req_mode)
         ppq_pkg::MODE_ADD:      dec_op = ppq_pkg::OP_ADD;
         ppq_pkg::MODE_DISPATCH: dec_op = ppq_pkg::OP_DISPATCH;
         ppq_pkg::MODE_REMOVE:   dec_op = ppq_pkg::OP_REMOVE;
         default:                dec_op = ppq_pkg::OP_NOP;
      endcase
      dec_prio = (dec_op == ppq_pkg::OP_ADD) ? req_prio : '0;
   end

   assign req_ready = (fill_ff != 2'(Slots));
   assign cmd_valid = (fill_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   assign cmd_op   = op_ff[rd_ptr_ff];
   assign cmd_pid  = pid_ff[rd_ptr_ff];
   assign cmd_prio = prio_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= dec_op;
         pid_ff[wr_ptr_ff]  <= req_pid;
         prio_ff[wr_ptr_ff] <= dec_prio;
      end
   end

endmodule

// ===== sv/ppq_back.sv =====
module ppq_back #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 16,
   parameter int PRIO_BITS   = 8,
   parameter int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  ppq_pkg::op_type        cmd_op,
   input  logic [ID_BITS-1:0]     cmd_pid,
   input  logic [PRIO_BITS-1:0]   cmd_prio,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_run_valid,
   output logic [ID_BITS-1:0]     rsp_run_pid,
   output logic [PRIO_BITS-1:0]   rsp_run_prio,
   output logic [COUNT_BITS-1:0]  rsp_queue_count,
   output ppq_pkg::status_type    rsp_status
);

   localparam int AddrBits  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int EntryBits = ID_BITS + PRIO_BITS;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_INS_LAST = 3'd2;
   localparam logic [2:0] S_DSP_HEAD = 3'd3;
   localparam logic [2:0] S_DSP      = 3'd4;
   localparam logic [2:0] S_REM      = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  run_valid_ff, run_valid_in;
   logic [ID_BITS-1:0]    run_id_ff, run_id_in;
   logic [PRIO_BITS-1:0]  run_prio_ff, run_prio_in;
   logic [COUNT_BITS-1:0] len_ff, len_in;
   logic [AddrBits-1:0]   ptr_ff, ptr_in;
   logic [COUNT_BITS-1:0] wr_ff, wr_in;
   logic                  found_ff, found_in;
   logic [ID_BITS-1:0]    ins_id_ff, ins_id_in;
   logic [PRIO_BITS-1:0]  ins_prio_ff, ins_prio_in;
   logic [ID_BITS-1:0]    key_id_ff, key_id_in;
   ppq_pkg::status_type   status_ff, status_in;

   logic                  rsp_valid_ff;
   logic                  rsp_run_valid_ff;
   logic [ID_BITS-1:0]    rsp_run_pid_ff;
   logic [PRIO_BITS-1:0]  rsp_run_prio_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   ppq_pkg::status_type   rsp_status_ff;
   logic                  rsp_load;

   logic [EntryBits-1:0]  mem_ff [QUEUE_DEPTH];
   logic [EntryBits-1:0]  rd_data_ff;
   logic                  mem_we;
   logic [AddrBits-1:0]   mem_waddr;
   logic [EntryBits-1:0]  mem_wdata;
   logic [AddrBits-1:0]   mem_raddr;

   logic [ID_BITS-1:0]    rd_id;
   logic [PRIO_BITS-1:0]  rd_prio;
   logic [COUNT_BITS-1:0] len_last;
   logic [COUNT_BITS-1:0] ptr_ext;
   logic                  rem_match;

   assign rd_id     = rd_data_ff[EntryBits-1:PRIO_BITS];
   assign rd_prio   = rd_data_ff[PRIO_BITS-1:0];
   assign len_last  = len_ff - 1'b1;
   assign ptr_ext   = COUNT_BITS'(ptr_ff);
   assign rem_match = (rd_id == key_id_ff);

   always_comb begin
      state_in     = state_ff;
      run_valid_in = run_valid_ff;
      run_id_in    = run_id_ff;
      run_prio_in  = run_prio_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      wr_in        = wr_ff;
      found_in     = found_ff;
      ins_id_in    = ins_id_ff;
      ins_prio_in  = ins_prio_ff;
      key_id_in    = key_id_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = ptr_ff;
      cmd_ready    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               key_id_in = cmd_pid;
               status_in = ppq_pkg::STATUS_OK;
               state_in  = S_DONE;
               unique case (cmd_op)
                  ppq_pkg::OP_ADD: begin
                     if (!run_valid_ff) begin
                        run_valid_in = 1'b1;
                        run_id_in    = cmd_pid;
                        run_prio_in  = cmd_prio;
                     end else if (len_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                        status_in = ppq_pkg::STATUS_FULL;
                     end else begin
                        // strictly higher priority preempts; the runner goes to the queue
                        if (run_prio_ff < cmd_prio) begin
                           ins_id_in   = run_id_ff;
                           ins_prio_in = run_prio_ff;
                           run_id_in   = cmd_pid;
                           run_prio_in = cmd_prio;
                        end else begin
                           ins_id_in   = cmd_pid;
                           ins_prio_in = cmd_prio;
                        end
                        if (len_ff == '0) begin
                           ptr_in   = '0;
                           state_in = S_INS_LAST;
                        end else begin
                           mem_raddr = len_last[AddrBits-1:0];
                           ptr_in    = len_last[AddrBits-1:0];
                           state_in  = S_INS;
                        end
                     end
                  end
                  ppq_pkg::OP_DISPATCH: begin
                     if (len_ff == '0) begin
                        run_valid_in = 1'b0;
                        run_id_in    = '0;
                        run_prio_in  = '0;
                     end else begin
                        mem_raddr = '0;
                        state_in  = S_DSP_HEAD;
                     end
                  end
                  ppq_pkg::OP_REMOVE: begin
                     if (len_ff == '0) begin
                        status_in = ppq_pkg::STATUS_NOT_FOUND;
                     end else begin
                        mem_raddr = '0;
                        ptr_in    = '0;
                        wr_in     = '0;
                        found_in  = 1'b0;
                        state_in  = S_REM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // walk down from the tail, moving lower-priority entries up by one
         S_INS: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + 1'b1;
            if (rd_prio < ins_prio_ff) begin
               mem_wdata = rd_data_ff;
               if (ptr_ff == '0) begin
                  state_in = S_INS_LAST;
               end else begin
                  mem_raddr = ptr_ff - 1'b1;
                  ptr_in    = ptr_ff - 1'b1;
               end
            end else begin
               mem_wdata = {ins_id_ff, ins_prio_ff};
               len_in    = len_ff + 1'b1;
               state_in  = S_DONE;
            end
         end

         S_INS_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = {ins_id_ff, ins_prio_ff};
            len_in    = len_ff + 1'b1;
            state_in  = S_DONE;
         end

         S_DSP_HEAD: begin
            run_valid_in = 1'b1;
            run_id_in    = rd_id;
            run_prio_in  = rd_prio;
            len_in       = len_last;
            if (len_ff == COUNT_BITS'(1)) begin
               state_in = S_DONE;
            end else begin
               mem_raddr = AddrBits'(1);
               ptr_in    = AddrBits'(1);
               state_in  = S_DSP;
            end
         end

         // shift the rest down by one; len already holds the new count
         S_DSP: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff - 1'b1;
            mem_wdata = rd_data_ff;
            if (ptr_ext == len_ff) begin
               state_in = S_DONE;
            end else begin
               mem_raddr = ptr_ff + 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end

         // compact: keep non-matching entries at the write pointer
         S_REM: begin
            if (rem_match) begin
               found_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = wr_ff[AddrBits-1:0];
               mem_wdata = rd_data_ff;
               wr_in     = wr_ff + 1'b1;
            end
            if (ptr_ext == len_last) begin
               len_in    = rem_match ? wr_ff : wr_ff + 1'b1;
               status_in = (rem_match || found_ff) ? ppq_pkg::STATUS_OK
                                                   : ppq_pkg::STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               mem_raddr = ptr_ff + 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         run_prio_ff  <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         run_id_ff    <= run_id_in;
         run_prio_ff  <= run_prio_in;
         len_ff       <= len_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      wr_ff       <= wr_in;
      found_ff    <= found_in;
      ins_id_ff   <= ins_id_in;
      ins_prio_ff <= ins_prio_in;
      key_id_ff   <= key_id_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_run_valid_ff <= run_valid_ff;
         rsp_run_pid_ff   <= run_valid_ff ? run_id_ff : '0;
         rsp_run_prio_ff  <= run_valid_ff ? run_prio_ff : '0;
         rsp_count_ff     <= len_ff;
         rsp_status_ff    <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_valid   = rsp_run_valid_ff;
   assign rsp_run_pid     = rsp_run_pid_ff;
   assign rsp_run_prio    = rsp_run_prio_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== sv/preemptive_priority_ready_queue_unit.sv =====
// channel   direction  handshake                payload
// req       in         req_valid / req_ready    req_mode, req_pid, req_prio
// rsp       out        rsp_valid / rsp_ready    rsp_run_valid, rsp_run_pid, rsp_run_prio,
//                                               rsp_queue_count, rsp_status
//
// A two-beat command buffer parts the front from the back, which walks the queue memory.
// rsp_valid rises without a walk of the queue memory for an add into an empty slot, a full
// reject, a nop, an empty dispatch or a remove on an empty queue; an insert, a dispatch or a
// remove over a queue of N entries steps one entry per cycle through the queue memory
// (one read and one write port).
// Reset is synchronous: slot empty, queue empty, no result pending; the queue memory
// is not cleared. A stalled rsp holds the back; the front keeps taking beats until full.
module preemptive_priority_ready_queue_unit #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 16,
   parameter int PRIO_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ppq_pkg::mode_type                       req_mode,
   input  logic [ID_BITS-1:0]                      req_pid,
   input  logic [PRIO_BITS-1:0]                    req_prio,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_run_valid,
   output logic [ID_BITS-1:0]                      rsp_run_pid,
   output logic [PRIO_BITS-1:0]                    rsp_run_prio,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      rsp_queue_count,
   output ppq_pkg::status_type                     rsp_status
);

   logic                  cmd_valid;
   logic                  cmd_ready;
   ppq_pkg::op_type       cmd_op;
   logic [ID_BITS-1:0]    cmd_pid;
   logic [PRIO_BITS-1:0]  cmd_prio;

   ppq_front #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_pid   (req_pid),
      .req_prio  (req_prio),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_op    (cmd_op),
      .cmd_pid   (cmd_pid),
      .cmd_prio  (cmd_prio)
   );

   ppq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .PRIO_BITS   (PRIO_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd_op          (cmd_op),
      .cmd_pid         (cmd_pid),
      .cmd_prio        (cmd_prio),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_valid   (rsp_run_valid),
      .rsp_run_pid     (rsp_run_pid),
      .rsp_run_prio    (rsp_run_prio),
      .rsp_queue_count (rsp_queue_count),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== sv/ppq_checker.sv =====
module ppq_checker #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 16,
   parameter int PRIO_BITS   = 8
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_run_valid,
   input logic [ID_BITS-1:0]                  rsp_run_pid,
   input logic [PRIO_BITS-1:0]                rsp_run_prio,
   input logic [$clog2(QUEUE_DEPTH + 1)-1:0]  rsp_queue_count,
   input ppq_pkg::status_type                 rsp_status
);

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_run_valid, rsp_run_pid, rsp_run_prio, rsp_queue_count, rsp_status}))
      else $error("rsp beat changed while stalled");

   a_empty_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_valid |-> rsp_run_pid == '0 && rsp_run_prio == '0)
      else $error("empty slot reports nonzero pid or prio");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= CountBits'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ppq_pkg::STATUS_FULL |->
         rsp_run_valid && rsp_queue_count == CountBits'(QUEUE_DEPTH))
      else $error("full reject without a full queue and a runner");

   a_queue_needs_runner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_count != '0 |-> rsp_run_valid)
      else $error("waiting entries with an empty running slot");

endmodule

bind preemptive_priority_ready_queue_unit ppq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .ID_BITS     (ID_BITS),
   .PRIO_BITS   (PRIO_BITS)
) u_ppq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_run_valid   (rsp_run_valid),
   .rsp_run_pid     (rsp_run_pid),
   .rsp_run_prio    (rsp_run_prio),
   .rsp_queue_count (rsp_queue_count),
   .rsp_status      (rsp_status)
);
